>>> hdl/button_click_hold_detector_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the button click / hold detector
// Shared shorthand for the concurrent checks on the block's ports.
// ----------------------------------------------------------------------------
`ifndef BUTTON_CLICK_HOLD_DETECTOR_ASSERT_SVH
`define BUTTON_CLICK_HOLD_DETECTOR_ASSERT_SVH

// Check that is switched off while reset is asserted.
`define BCHD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check that also holds across reset.
`define BCHD_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hdl/bchd_pkg.sv
// ----------------------------------------------------------------------------
// bchd_pkg
// Types and constants shared by the button click / hold detector files.
// ----------------------------------------------------------------------------
package bchd_pkg;

  localparam int TIME_WIDTH_DEF = 32;
  localparam int NOW_W          = 32;
  localparam int CFG_W          = 16;
  localparam int CFG_INDEX_W    = 2;
  localparam int EVENT_W        = 3;

  // Stream payload widths, rounded up to whole bytes.
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 8;

  localparam logic [CFG_INDEX_W-1:0] REG_DEBOUNCE = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_DC_GAP   = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_HOLD     = 2'd2;

  localparam logic [CFG_W-1:0] DEBOUNCE_RST = 16'd20;
  localparam logic [CFG_W-1:0] DC_GAP_RST   = 16'd250;
  localparam logic [CFG_W-1:0] HOLD_RST     = 16'd1000;

  typedef enum logic [EVENT_W-1:0] {
    EV_NONE      = 3'd0,
    EV_SINGLE    = 3'd1,
    EV_DOUBLE    = 3'd2,
    EV_HOLD      = 3'd3,
    EV_HOLD_CONT = 3'd4
  } event_t;

endpackage

>>> hdl/button_click_hold_detector.sv
// ----------------------------------------------------------------------------
// button_click_hold_detector
// Click, double click and hold detection on timestamped button samples.
// ----------------------------------------------------------------------------
// Usage:
//   Each input transaction on s_axis carries one sample of an active-low
//   button pin and the free-running millisecond timestamp of that sample.
//   Every input transaction yields exactly one output transaction on m_axis
//   with an event code: none, single click, double click, hold start or hold
//   continuing. Debounce, double-click gap and hold thresholds are written
//   through the cfg port; the user is bound to write them only while the
//   block is idle, which the block itself does not enforce. A sample passes
//   from input acceptance through the input register, then through the
//   decision logic into the result register, where the button state is also
//   updated. Throughput is one sample per cycle while m_axis_tready is high;
//   the state update is a single pass of subtract and compare logic.
//   Reset (synchronous, active high) empties both registers, restores the
//   default thresholds (20, 250 and 1000 ms) and the idle button state.
//   When m_axis_tready is low a waiting result holds, as does a full input
//   register; s_axis_tready drops only once both are full.
// ----------------------------------------------------------------------------
module button_click_hold_detector #(
  parameter int TIME_WIDTH = bchd_pkg::TIME_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  // Configuration write port.
  input  logic                               cfg_we,
  input  logic [bchd_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [bchd_pkg::CFG_W-1:0]         cfg_data,
  // Input samples.
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // Fields from bit 0: button_level [0], now_ms [32:1], zero padding.
  input  logic [bchd_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  // Events.
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // Fields from bit 0: event_code [2:0], zero padding.
  output logic [bchd_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);
  import bchd_pkg::*;

  localparam int NowKeep = (TIME_WIDTH < NOW_W) ? TIME_WIDTH : NOW_W;

  // Threshold registers.
  logic [CFG_W-1:0] debounce_ms;
  logic [CFG_W-1:0] dc_gap_ms;
  logic [CFG_W-1:0] hold_ms;

  // Input register.
  logic                  in_valid;
  logic                  in_level;
  logic [NOW_W-1:0]      in_now;

  // Result register.
  logic                  out_valid;
  event_t                out_code;

  // Button state.
  logic                  last_level;
  logic [TIME_WIDTH-1:0] press_time;
  logic [TIME_WIDTH-1:0] release_time;
  logic                  ignore_release;
  logic                  single_allowed;
  logic                  hold_reported;
  logic                  second_press_seen;
  logic                  awaiting_second;

  logic [TIME_WIDTH-1:0] press_time_next;
  logic [TIME_WIDTH-1:0] release_time_next;
  logic                  ignore_release_next;
  logic                  single_allowed_next;
  logic                  hold_reported_next;
  logic                  second_press_seen_next;
  logic                  awaiting_second_next;
  event_t                code_next;

  logic                  advance;
  logic [TIME_WIDTH-1:0] now_t;
  logic [TIME_WIDTH-1:0] since_up;
  logic [TIME_WIDTH-1:0] since_down;
  logic [TIME_WIDTH-1:0] up_after;
  logic [TIME_WIDTH-1:0] down_after;
  logic [TIME_WIDTH-1:0] deb_t;
  logic [TIME_WIDTH-1:0] gap_t;
  logic [TIME_WIDTH-1:0] hold_t;
  logic                  press_edge;
  logic                  release_edge;
  logic                  release_taken;

  assign advance       = !out_valid || m_axis_tready;
  assign s_axis_tready = !in_valid || advance;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = OUT_TDATA_W'(out_code);

  assign now_t      = TIME_WIDTH'(in_now[NowKeep-1:0]);
  assign deb_t      = TIME_WIDTH'(debounce_ms);
  assign gap_t      = TIME_WIDTH'(dc_gap_ms);
  assign hold_t     = TIME_WIDTH'(hold_ms);
  assign since_up   = now_t - release_time;
  assign since_down = now_t - press_time;

  assign press_edge    = !in_level && last_level && (since_up > deb_t);
  assign release_edge  = in_level && !last_level && (since_down > deb_t);
  assign release_taken = release_edge && !ignore_release;

  // Elapsed times as seen after an edge restamps press or release time.
  assign up_after   = release_taken ? '0 : since_up;
  assign down_after = press_edge ? '0 : since_down;

  always_comb begin
    press_time_next        = press_time;
    release_time_next      = release_time;
    ignore_release_next    = ignore_release;
    single_allowed_next    = single_allowed;
    hold_reported_next     = hold_reported;
    second_press_seen_next = second_press_seen;
    awaiting_second_next   = awaiting_second;
    code_next              = EV_NONE;

    if (press_edge) begin
      press_time_next        = now_t;
      ignore_release_next    = 1'b0;
      single_allowed_next    = 1'b1;
      hold_reported_next     = 1'b0;
      second_press_seen_next = (since_up < gap_t) && !second_press_seen && awaiting_second;
      awaiting_second_next   = 1'b0;
    end else if (release_taken) begin
      release_time_next = now_t;
      if (!second_press_seen) begin
        awaiting_second_next = 1'b1;
      end else begin
        code_next              = EV_DOUBLE;
        second_press_seen_next = 1'b0;
        awaiting_second_next   = 1'b0;
        single_allowed_next    = 1'b0;
      end
    end

    // A release that saw no second press within the gap is a single click.
    if (in_level && (up_after >= gap_t) && awaiting_second_next &&
        !second_press_seen_next && single_allowed_next && (code_next != EV_DOUBLE)) begin
      code_next            = EV_SINGLE;
      awaiting_second_next = 1'b0;
    end

    if (!in_level && (down_after >= hold_t)) begin
      if (!hold_reported_next) begin
        code_next              = EV_HOLD;
        ignore_release_next    = 1'b1;
        second_press_seen_next = 1'b0;
        awaiting_second_next   = 1'b0;
        hold_reported_next     = 1'b1;
      end else begin
        code_next = EV_HOLD_CONT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ms <= DEBOUNCE_RST;
      dc_gap_ms   <= DC_GAP_RST;
      hold_ms     <= HOLD_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DEBOUNCE: debounce_ms <= cfg_data;
        REG_DC_GAP:   dc_gap_ms   <= cfg_data;
        REG_HOLD:     hold_ms     <= cfg_data;
        default:      ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
    if (s_axis_tready && s_axis_tvalid) begin
      in_level <= s_axis_tdata[0];
      in_now   <= s_axis_tdata[NOW_W:1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid         <= 1'b0;
      last_level        <= 1'b1;
      press_time        <= '0;
      release_time      <= '0;
      ignore_release    <= 1'b0;
      single_allowed    <= 1'b1;
      hold_reported     <= 1'b0;
      second_press_seen <= 1'b0;
      awaiting_second   <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
      if (in_valid) begin
        out_code          <= code_next;
        last_level        <= in_level;
        press_time        <= press_time_next;
        release_time      <= release_time_next;
        ignore_release    <= ignore_release_next;
        single_allowed    <= single_allowed_next;
        hold_reported     <= hold_reported_next;
        second_press_seen <= second_press_seen_next;
        awaiting_second   <= awaiting_second_next;
      end
    end
  end

endmodule

>>> hdl/bchd_checker.sv
// ----------------------------------------------------------------------------
// bchd_checker
// Port-level checks for the button click / hold detector, bound to the top.
// ----------------------------------------------------------------------------
`include "button_click_hold_detector_assert.svh"

module bchd_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               s_axis_tready,
  input logic                               m_axis_tvalid,
  input logic                               m_axis_tready,
  input logic [bchd_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);
  import bchd_pkg::*;

  // The output side is empty on the edge that follows a reset cycle.
  `BCHD_ASSERT_ALWAYS(a_empty_after_rst, rst |=> !m_axis_tvalid, "result after reset")

  // With no result waiting, the input side can always take a transaction.
  `BCHD_ASSERT(a_ready_when_empty, !m_axis_tvalid |-> s_axis_tready, "stalled while empty")

  // Padding above the event code stays zero.
  `BCHD_ASSERT(a_pad_zero, m_axis_tvalid |-> m_axis_tdata[OUT_TDATA_W-1:EVENT_W] == '0,
               "nonzero padding")

  // A stalled result holds.
  `BCHD_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=>
               m_axis_tvalid && $stable(m_axis_tdata), "result dropped under stall")

endmodule

bind button_click_hold_detector bchd_checker u_bchd_checker (.*);
